/* rtl/modexp_pkg.sv */
// Shared constants and unit interface types of the modular exponentiation block.
// Depends on nothing; used by modexp_mulmod and modular_exponentiation.
package modexp_pkg;

  localparam int OPERAND_WIDTH = 48;
  localparam int CNT_W         = $clog2(OPERAND_WIDTH);

  typedef logic [OPERAND_WIDTH-1:0] operand_t;

  typedef struct packed {
    logic     start;
    operand_t a;
    operand_t b;
    operand_t m;
  } mm_req_t;

  typedef struct packed {
    logic     done;
    operand_t result;
  } mm_rsp_t;

endpackage

/* rtl/modexp_mulmod.sv */
// Serial modular multiplier: (a * b) mod m by double-and-add, one multiplier bit per cycle.
// Depends on modexp_pkg. Operand a must already be below m, and m must be nonzero.
module modexp_mulmod (
  input  logic                clk,
  input  logic                rst_n,
  input  modexp_pkg::mm_req_t req,
  output modexp_pkg::mm_rsp_t rsp
);

  localparam int W = modexp_pkg::OPERAND_WIDTH;

  logic                         busy_r;
  logic                         busy_nxt;
  logic                         done_r;
  logic                         done_nxt;
  logic [modexp_pkg::CNT_W-1:0] cnt_r;
  logic [modexp_pkg::CNT_W-1:0] cnt_nxt;
  modexp_pkg::operand_t         acc_r;
  modexp_pkg::operand_t         acc_nxt;
  modexp_pkg::operand_t         a_r;
  modexp_pkg::operand_t         a_nxt;
  modexp_pkg::operand_t         b_r;
  modexp_pkg::operand_t         b_nxt;
  modexp_pkg::operand_t         mod_r;
  modexp_pkg::operand_t         mod_nxt;
  logic [W+1:0]                 sum;
  logic [W+1:0]                 diff1;
  logic [W+1:0]                 diff2;

  // 2*acc + bit*a stays below 3m: subtract m or 2m where it fits
  always_comb begin
    sum   = {1'b0, acc_r, 1'b0} + {2'b00, (b_r[W-1] ? a_r : '0)};
    diff1 = sum - {2'b00, mod_r};
    diff2 = sum - {1'b0, mod_r, 1'b0};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    mod_nxt  = mod_r;
    if (busy_r) begin
      priority if (!diff2[W+1]) begin
        acc_nxt = diff2[W-1:0];
      end else if (!diff1[W+1]) begin
        acc_nxt = diff1[W-1:0];
      end else begin
        acc_nxt = sum[W-1:0];
      end
      b_nxt = {b_r[W-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = modexp_pkg::CNT_W'(W - 1);
      acc_nxt  = '0;
      a_nxt    = req.a;
      b_nxt    = req.b;
      mod_nxt  = req.m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    mod_r <= mod_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (acc_r < mod_r))
    else $error("partial product not reduced");

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("multiplier done held two cycles");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r != '0) |=> busy_r && !done_r)
    else $error("multiplier finished early");

endmodule

/* rtl/modular_exponentiation.sv */
// Top level of the modular exponentiation block: sequencer around one serial modular multiplier.
// Depends on modexp_pkg and modexp_mulmod.
//
// Computes base ** exponent mod modulus by right-to-left square-and-multiply. An item is taken
// when start is high and busy is low. A zero exponent returns 1 and a zero modulus (with nonzero
// exponent) returns 0, both in the cycle after the item is taken, and busy stays low for them.
// Every other item raises busy until its result is out. The result appears on
// out_power_result for exactly one cycle with out_valid high and cannot be held off.
// Every step runs on the shared bit-serial multiplier, one modular product at a time: one reduction
// of the base, one product for each one bit of the exponent and one square for each bit below
// the highest one, plus a decision state (S_CHK) for each bit.
module modular_exponentiation (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  modexp_pkg::operand_t in_base,
  input  modexp_pkg::operand_t in_exponent,
  input  modexp_pkg::operand_t in_modulus,
  output logic                 out_valid,
  output modexp_pkg::operand_t out_power_result
);

  localparam int W = modexp_pkg::OPERAND_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RED  = 5'b00010,
    S_CHK  = 5'b00100,
    S_MUL  = 5'b01000,
    S_SQR  = 5'b10000
  } state_t;

  state_t               state_r;
  state_t               state_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  modexp_pkg::operand_t out_res_r;
  modexp_pkg::operand_t out_res_nxt;
  modexp_pkg::operand_t acc_r;
  modexp_pkg::operand_t acc_nxt;
  modexp_pkg::operand_t sq_r;
  modexp_pkg::operand_t sq_nxt;
  modexp_pkg::operand_t exp_r;
  modexp_pkg::operand_t exp_nxt;
  modexp_pkg::operand_t mod_r;
  modexp_pkg::operand_t mod_nxt;
  modexp_pkg::operand_t one_mod;
  modexp_pkg::mm_req_t  mm_req;
  modexp_pkg::mm_rsp_t  mm_rsp;

  modexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  assign one_mod = (in_modulus == W'(1)) ? '0 : W'(1);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    exp_nxt       = exp_r;
    mod_nxt       = mod_r;
    mm_req.start  = 1'b0;
    mm_req.a      = acc_r;
    mm_req.b      = sq_r;
    mm_req.m      = mod_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          exp_nxt = in_exponent;
          mod_nxt = in_modulus;
          priority if (in_exponent == '0) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = W'(1);
          end else if (in_modulus == '0) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = '0;
          end else begin
            // reduce the base as one_mod * base
            acc_nxt      = one_mod;
            mm_req.start = 1'b1;
            mm_req.a     = one_mod;
            mm_req.b     = in_base;
            mm_req.m     = in_modulus;
            state_nxt    = S_RED;
          end
        end
      end
      S_RED: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.result;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        mm_req.start = 1'b1;
        if (exp_r[0]) begin
          state_nxt = S_MUL;
        end else begin
          mm_req.a  = sq_r;
          exp_nxt   = {1'b0, exp_r[W-1:1]};
          state_nxt = S_SQR;
        end
      end
      S_MUL: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.result;
          exp_nxt = {1'b0, exp_r[W-1:1]};
          if (exp_r[W-1:1] == '0) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = mm_rsp.result;
            state_nxt     = S_IDLE;
          end else begin
            mm_req.start = 1'b1;
            mm_req.a     = sq_r;
            state_nxt    = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.result;
          state_nxt = S_CHK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    acc_r     <= acc_nxt;
    sq_r      <= sq_nxt;
    exp_r     <= exp_nxt;
    mod_r     <= mod_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_res_r;

  a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_exponent == '0) |=> (out_valid && out_power_result == W'(1)))
    else $error("zero exponent must return one");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while busy");

  a_chk_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (exp_r != '0))
    else $error("exponent exhausted before result");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (state_r == S_RED || state_r == S_MUL || state_r == S_SQR))
    else $error("product finished outside a waiting state");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_MUL) && mm_rsp.done) |-> (mm_rsp.result < mod_r))
    else $error("product not reduced");

endmodule
